// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the checker files of the UTF-8 stream decoder.
// Depends on nothing; included by each file that holds assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge, suspended while reset is held.
`define U8D_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property at every rising clock edge, including during reset.
`define U8D_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/u8d_pkg.sv -----
// Types and constants of the UTF-8 stream decoder.
// Used by the front, queue, back, top level and checker files.
package u8d_pkg;

    localparam int CP_W        = 21;
    localparam int LEN_W       = 3;
    localparam int CNT_OUT_W   = 16;
    localparam int S_DATA_W    = 8;
    localparam int M_DATA_W    = 40;
    localparam int M_USER_W    = 2;
    localparam int QUEUE_DEPTH = 2;

    // Lead and continuation byte patterns.
    localparam logic [7:0] LEAD2_MASK = 8'hE0;
    localparam logic [7:0] LEAD2_CODE = 8'hC0;
    localparam logic [7:0] LEAD3_MASK = 8'hF0;
    localparam logic [7:0] LEAD3_CODE = 8'hE0;
    localparam logic [7:0] LEAD4_MASK = 8'hF8;
    localparam logic [7:0] LEAD4_CODE = 8'hF0;
    localparam logic [7:0] LEAD4_MAX  = 8'hF4;
    localparam logic [7:0] CONT_MASK  = 8'hC0;
    localparam logic [7:0] CONT_CODE  = 8'h80;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_LEAD = 2'd1,
        ST_BAD_CONT = 2'd2,
        ST_TRUNC    = 2'd3
    } t_status;

    // One result as classified by the front, before the character count is applied.
    typedef struct packed {
        logic [CP_W-1:0]  codepoint;
        logic [LEN_W-1:0] seq_len;
        t_status          status;
        logic             last;
    } t_event;

endpackage

// ----- rtl/utf8_stream_decoder_core.sv -----
// Channel   Dir  tdata (low bit up)                                    tuser        tlast
// s         in   data_byte[7:0]                                        -            last_byte
// m         out  codepoint[20:0] seq_length[23:21] char_count[39:24]  status[1:0]  end_of_string
//
// One byte is taken per clock while the queue is not full. Classification in the front is
// combinational, so a result is written into the queue at the edge that accepts its byte
// and appears on the m side once the back has moved it into the output register.
// Reset (i_rst_n low at a clock edge) closes any open sequence and clears the count.
// A two-entry queue decouples the front from the output register, so a stall on the
// m side stops the s side only once the queue has filled.
// Top level of the UTF-8 stream decoder; depends on u8d_pkg, u8d_front,
// u8d_queue and u8d_back.
module utf8_stream_decoder_core #(
    parameter int COUNT_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [u8d_pkg::S_DATA_W-1:0]   i_s_tdata,   // data_byte[7:0]
    input  logic                           i_s_tlast,
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [u8d_pkg::M_DATA_W-1:0]   o_m_tdata,   // codepoint, seq_length, char_count
    output logic [u8d_pkg::M_USER_W-1:0]   o_m_tuser,   // status[1:0]
    output logic                           o_m_tlast
);

    logic            w_push, w_pop, w_full, w_empty;
    u8d_pkg::t_event w_front_ev, w_back_ev;

    u8d_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_s_tvalid),
        .i_byte       (i_s_tdata),
        .i_last       (i_s_tlast),
        .i_queue_full (w_full),
        .o_ready      (o_s_tready),
        .o_push       (w_push),
        .o_event      (w_front_ev)
    );

    u8d_queue #(
        .DEPTH (u8d_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_data  (w_front_ev),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_data  (w_back_ev)
    );

    u8d_back #(
        .COUNT_BITS (COUNT_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (w_empty),
        .i_event    (w_back_ev),
        .o_pop      (w_pop),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

// ----- rtl/u8d_front.sv -----
// Front of the UTF-8 stream decoder: accepts bytes, tracks the open sequence
// and classifies each byte into a result event. Depends on u8d_pkg.
module u8d_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    input  logic              i_queue_full,
    output logic              o_ready,
    output logic              o_push,
    output u8d_pkg::t_event   o_event
);

    logic [1:0]                  r_pending, n_pending;
    logic [u8d_pkg::CP_W-1:0]    r_partial, n_partial;
    logic [u8d_pkg::LEN_W-1:0]   r_open_len, n_open_len;
    logic                        w_accept;
    logic                        w_has_res;
    logic [u8d_pkg::CP_W-1:0]    w_acc;
    u8d_pkg::t_event             w_ev;

    assign o_ready  = !i_queue_full;
    assign w_accept = i_valid && o_ready;
    assign w_acc    = {r_partial[u8d_pkg::CP_W-7:0], i_byte[5:0]};

    always_comb begin
        n_pending     = r_pending;
        n_partial     = r_partial;
        n_open_len    = r_open_len;
        w_has_res     = 1'b0;
        w_ev.codepoint = '0;
        w_ev.seq_len   = 3'd1;
        w_ev.status    = u8d_pkg::ST_OK;
        w_ev.last      = i_last;

        if (r_pending == 2'd0) begin
            priority if (i_byte[7] == 1'b0) begin
                w_has_res      = 1'b1;
                w_ev.codepoint = u8d_pkg::CP_W'(i_byte);
            end else if ((i_byte & u8d_pkg::LEAD2_MASK) == u8d_pkg::LEAD2_CODE) begin
                n_partial  = u8d_pkg::CP_W'(i_byte[4:0]);
                n_open_len = 3'd2;
                n_pending  = 2'd1;
            end else if ((i_byte & u8d_pkg::LEAD3_MASK) == u8d_pkg::LEAD3_CODE) begin
                n_partial  = u8d_pkg::CP_W'(i_byte[3:0]);
                n_open_len = 3'd3;
                n_pending  = 2'd2;
            end else if ((i_byte & u8d_pkg::LEAD4_MASK) == u8d_pkg::LEAD4_CODE
                         && i_byte <= u8d_pkg::LEAD4_MAX) begin
                n_partial  = u8d_pkg::CP_W'(i_byte[2:0]);
                n_open_len = 3'd4;
                n_pending  = 2'd3;
            end else begin
                w_has_res   = 1'b1;
                w_ev.status = u8d_pkg::ST_BAD_LEAD;
            end
        end else if ((i_byte & u8d_pkg::CONT_MASK) == u8d_pkg::CONT_CODE) begin
            n_pending = r_pending - 2'd1;
            if (r_pending == 2'd1) begin
                w_has_res      = 1'b1;
                w_ev.codepoint = w_acc;
                w_ev.seq_len   = r_open_len;
                n_partial      = '0;
                n_open_len     = '0;
            end else begin
                n_partial = w_acc;
            end
        end else begin
            // The offending byte is counted among the dropped bytes.
            w_has_res    = 1'b1;
            w_ev.status  = u8d_pkg::ST_BAD_CONT;
            w_ev.seq_len = r_open_len - {1'b0, r_pending} + 3'd1;
            n_pending    = '0;
            n_partial    = '0;
            n_open_len   = '0;
        end

        if (i_last) begin
            if (!w_has_res) begin
                w_has_res    = 1'b1;
                w_ev.status  = u8d_pkg::ST_TRUNC;
                w_ev.seq_len = n_open_len - {1'b0, n_pending};
            end
            n_pending  = '0;
            n_partial  = '0;
            n_open_len = '0;
        end
    end

    assign o_push  = w_accept && w_has_res;
    assign o_event = w_ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending  <= '0;
            r_partial  <= '0;
            r_open_len <= '0;
        end else if (w_accept) begin
            r_pending  <= n_pending;
            r_partial  <= n_partial;
            r_open_len <= n_open_len;
        end
    end

endmodule

// ----- rtl/u8d_queue.sv -----
// Short queue of classified events between the front and the back.
// Depends on u8d_pkg for the event type.
module u8d_queue #(
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  u8d_pkg::t_event  i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_empty,
    output u8d_pkg::t_event  o_data
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    u8d_pkg::t_event r_mem [DEPTH];
    logic [AW-1:0]   r_wr, r_rd;
    logic [CW-1:0]   r_cnt;
    logic            w_push, w_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign w_push  = i_push && !o_full;
    assign w_pop   = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
            end
            if (w_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
            end
            if (w_push && !w_pop) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (w_pop && !w_push) begin
                r_cnt <= r_cnt - CW'(1);
            end
        end
    end

endmodule

// ----- rtl/u8d_back.sv -----
// Back of the UTF-8 stream decoder: applies the saturating character count
// and holds the result register. Depends on u8d_pkg.
module u8d_back #(
    parameter int COUNT_BITS = 16
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_empty,
    input  u8d_pkg::t_event                i_event,
    output logic                           o_pop,
    input  logic                           i_m_tready,
    output logic                           o_m_tvalid,
    output logic [u8d_pkg::M_DATA_W-1:0]   o_m_tdata,
    output logic [u8d_pkg::M_USER_W-1:0]   o_m_tuser,
    output logic                           o_m_tlast
);

    localparam logic [COUNT_BITS-1:0] CNT_MAX = {COUNT_BITS{1'b1}};

    logic [COUNT_BITS-1:0]               r_count, n_count;
    logic [31:0]                         w_count_ext;
    logic                                r_valid;
    logic [u8d_pkg::M_DATA_W-1:0]        r_data;
    logic [u8d_pkg::M_USER_W-1:0]        r_user;
    logic                                r_last;

    assign o_pop = !i_empty && (!r_valid || i_m_tready);

    always_comb begin
        n_count = r_count;
        if (i_event.status == u8d_pkg::ST_OK && r_count != CNT_MAX) begin
            n_count = r_count + COUNT_BITS'(1);
        end
    end

    assign w_count_ext = 32'(n_count);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            if (o_pop) begin
                r_valid <= 1'b1;
                r_count <= i_event.last ? '0 : n_count;
            end else if (i_m_tready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= {w_count_ext[u8d_pkg::CNT_OUT_W-1:0], i_event.seq_len,
                       i_event.codepoint};
            r_user <= i_event.status;
            r_last <= i_event.last;
        end
    end

    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = r_data;
    assign o_m_tuser  = r_user;
    assign o_m_tlast  = r_last;

endmodule

// ----- rtl/u8d_checker.sv -----
// Port-level checks on the UTF-8 stream decoder, bound to the top level.
// Depends on u8d_pkg and assert_macros.svh.
`include "assert_macros.svh"

module u8d_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [u8d_pkg::M_DATA_W-1:0]   o_m_tdata,
    input logic [u8d_pkg::M_USER_W-1:0]   o_m_tuser,
    input logic                           o_m_tlast
);

    logic w_err;
    logic w_one_byte_ok;

    assign w_err         = (o_m_tuser != u8d_pkg::ST_OK);
    assign w_one_byte_ok = !w_err && (o_m_tdata[23:21] == 3'd1);

    // A stalled item keeps its contents.
    `U8D_ASSERT(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast), "stalled result changed")

    // Error items carry no codepoint.
    `U8D_ASSERT(a_err_zero, i_clk, i_rst_n, o_m_tvalid && w_err |-> o_m_tdata[20:0] == 21'd0, "error result has a codepoint")

    // Every item accounts for one to four bytes.
    `U8D_ASSERT(a_len, i_clk, i_rst_n, o_m_tvalid |-> o_m_tdata[23:21] != 3'd0 && o_m_tdata[23:21] <= 3'd4, "sequence length out of range")

    // A one-byte character is plain ASCII.
    `U8D_ASSERT(a_ascii, i_clk, i_rst_n, o_m_tvalid && w_one_byte_ok |-> o_m_tdata[20:7] == 14'd0, "one-byte character above 0x7F")

endmodule

bind utf8_stream_decoder_core u8d_checker u_u8d_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for utf8_stream_decoder_core: byte items in, decoded characters out.
// Depends on u8d_pkg and the decoder RTL. The expected results come from a predictor
// kept in this file.
module testbench;

    localparam int      CLK_PERIOD  = 8;
    localparam int      COUNT_BITS  = 16;
    localparam longint  COUNT_MAX   = (64'd1 << COUNT_BITS) - 1;
    localparam int      STALL_LIMIT = 5000;
    localparam int      SETTLE      = 16;

    // Directed strings: 1- and 2-byte extremes, top 3- and 4-byte leads, then every error kind.
    localparam logic [7:0] GOOD_RUN [12] = '{8'h00, 8'h7F, 8'hC2, 8'h80, 8'hDF, 8'hBF,
                                             8'hEF, 8'hBF, 8'hBF, 8'hF4, 8'hBF, 8'hBF};
    localparam logic [7:0] BAD_RUN  [10] = '{8'h80, 8'hFF, 8'hF5, 8'hE2, 8'h82, 8'h41,
                                             8'hF0, 8'h80, 8'h80, 8'h80};

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_byte_item;

    typedef struct packed {
        logic [u8d_pkg::CP_W-1:0]      codepoint;
        logic [u8d_pkg::LEN_W-1:0]     seq_length;
        u8d_pkg::t_status              status;
        logic [u8d_pkg::CNT_OUT_W-1:0] char_count;
        logic                          end_flag;
    } t_decoded_char;

    logic                         i_clk      = 1'b0;
    logic                         i_rst_n    = 1'b0;
    logic                         i_s_tvalid = 1'b0;
    logic [u8d_pkg::S_DATA_W-1:0] i_s_tdata  = '0;
    logic                         i_s_tlast  = 1'b0;
    logic                         i_m_tready = 1'b0;
    logic                         o_s_tready;
    logic                         o_m_tvalid;
    logic [u8d_pkg::M_DATA_W-1:0] o_m_tdata;
    logic [u8d_pkg::M_USER_W-1:0] o_m_tuser;
    logic                         o_m_tlast;

    t_byte_item    bytes_to_send[$];
    t_decoded_char chars_due[$];
    int            bytes_offered  = 0;
    int            bytes_taken    = 0;
    int            mismatch_count = 0;
    int            stall_cycles   = 0;
    int            send_gap_pct   = 14;
    int            take_stall_pct = 74;

    // Predictor state: the character being assembled and the running count of the string.
    logic [1:0]               pend_conts = '0;
    logic [u8d_pkg::CP_W-1:0] cp_acc     = '0;
    logic [2:0]               char_len   = '0;
    longint                   char_total = 0;

    utf8_stream_decoder_core #(
        .COUNT_BITS (COUNT_BITS)
    ) DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .o_m_tlast  (o_m_tlast)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic t_decoded_char make_result(input logic [u8d_pkg::CP_W-1:0] cp,
                                                  input logic [2:0] len,
                                                  input u8d_pkg::t_status st,
                                                  input logic last);
        t_decoded_char r;
        r.codepoint  = cp;
        r.seq_length = len;
        r.status     = st;
        r.char_count = char_total[u8d_pkg::CNT_OUT_W-1:0];
        r.end_flag   = last;
        return r;
    endfunction

    task automatic decode_byte(input logic [7:0] b, input logic last);
        t_decoded_char res;
        logic          produced;
        logic          bad_lead;
        produced = 1'b0;
        bad_lead = 1'b0;
        if (pend_conts == 2'd0) begin
            casez (b)
                8'b0???????: begin
                    if (char_total < COUNT_MAX) char_total++;
                    res = make_result(u8d_pkg::CP_W'(b), 3'd1, u8d_pkg::ST_OK, last);
                    produced = 1'b1;
                end
                8'b110?????: begin
                    cp_acc = u8d_pkg::CP_W'(b[4:0]); char_len = 3'd2; pend_conts = 2'd1;
                end
                8'b1110????: begin
                    cp_acc = u8d_pkg::CP_W'(b[3:0]); char_len = 3'd3; pend_conts = 2'd2;
                end
                8'b11110???: begin
                    if (b <= 8'hF4) begin
                        cp_acc = u8d_pkg::CP_W'(b[2:0]); char_len = 3'd4; pend_conts = 2'd3;
                    end else begin
                        bad_lead = 1'b1;
                    end
                end
                default: bad_lead = 1'b1;
            endcase
            if (bad_lead) begin
                res = make_result('0, 3'd1, u8d_pkg::ST_BAD_LEAD, last);
                produced = 1'b1;
            end
        end else if (b[7:6] == 2'b10) begin
            cp_acc = {cp_acc[u8d_pkg::CP_W-7:0], b[5:0]};
            pend_conts = pend_conts - 2'd1;
            if (pend_conts == 2'd0) begin
                if (char_total < COUNT_MAX) char_total++;
                res = make_result(cp_acc, char_len, u8d_pkg::ST_OK, last);
                produced = 1'b1;
                cp_acc = '0; char_len = '0;
            end
        end else begin
            // The offending byte is dropped along with the partial character.
            res = make_result('0, 3'(char_len - {1'b0, pend_conts} + 3'd1),
                              u8d_pkg::ST_BAD_CONT, last);
            produced = 1'b1;
            pend_conts = '0; cp_acc = '0; char_len = '0;
        end
        if (last) begin
            if (!produced) begin
                res = make_result('0, 3'(char_len - {1'b0, pend_conts}), u8d_pkg::ST_TRUNC,
                                  1'b1);
                produced = 1'b1;
            end
            pend_conts = '0; cp_acc = '0; char_len = '0;
            char_total = 0;
        end
        if (produced) chars_due.push_back(res);
    endtask

    task automatic log_fault(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) $display("%s", msg);
    endtask

    // Both handshakes are sampled here at the rising edge, before the design updates.
    always @(posedge i_clk) begin
        t_decoded_char got;
        t_decoded_char want;
        logic          moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                decode_byte(i_s_tdata, i_s_tlast);
                bytes_taken++;
                moved = 1'b1;
            end
            if (o_m_tvalid && i_m_tready) begin
                moved = 1'b1;
                got.codepoint  = o_m_tdata[u8d_pkg::CP_W-1:0];
                got.seq_length = o_m_tdata[u8d_pkg::CP_W+u8d_pkg::LEN_W-1:u8d_pkg::CP_W];
                got.char_count = o_m_tdata[u8d_pkg::M_DATA_W-1:u8d_pkg::CP_W+u8d_pkg::LEN_W];
                got.status     = u8d_pkg::t_status'(o_m_tuser);
                got.end_flag   = o_m_tlast;
                if (chars_due.size() == 0) begin
                    log_fault($sformatf("unexpected result cp=%h len=%0d st=%0d cnt=%0d eos=%b",
                        got.codepoint, got.seq_length, got.status, got.char_count,
                        got.end_flag));
                end else begin
                    want = chars_due.pop_front();
                    if (got.codepoint !== want.codepoint || got.seq_length !== want.seq_length
                            || got.status !== want.status || got.char_count !== want.char_count
                            || got.end_flag !== want.end_flag) begin
                        log_fault({
                            $sformatf("mismatch: got cp=%h len=%0d st=%0d cnt=%0d eos=%b",
                                got.codepoint, got.seq_length, got.status, got.char_count,
                                got.end_flag),
                            $sformatf(", want cp=%h len=%0d st=%0d cnt=%0d eos=%b",
                                want.codepoint, want.seq_length, want.status,
                                want.char_count, want.end_flag)});
                    end
                end
            end
            stall_cycles = moved ? 0 : stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("timeout: no item moved for %0d cycles", STALL_LIMIT);
                $display("[utf8_stream_decoder_core] ERROR");
                $finish;
            end
        end
    end

    // The driver holds an item until it has been taken, then may idle before the next one.
    always @(negedge i_clk) begin
        t_byte_item nxt;
        if (i_rst_n && bytes_taken == bytes_offered) begin
            if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
                nxt = bytes_to_send.pop_front();
                i_s_tdata  <= nxt.data;
                i_s_tlast  <= nxt.last;
                i_s_tvalid <= 1'b1;
                bytes_offered++;
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
        i_m_tready <= ($urandom_range(99) >= take_stall_pct);
    end

    function automatic logic [7:0] lead_byte(input int len);
        case (len)
            1:       return 8'($urandom_range(8'h7F, 8'h00));
            2:       return 8'($urandom_range(8'hDF, 8'hC0));
            3:       return 8'($urandom_range(8'hEF, 8'hE0));
            default: return 8'($urandom_range(8'hF4, 8'hF0));
        endcase
    endfunction

    function automatic logic [7:0] cont_byte();
        return 8'($urandom_range(8'hBF, 8'h80));
    endfunction

    // Queues one string; each of its characters is given a flaw with a chance of flaw_pct percent.
    task automatic queue_string(input int n_chars, input int flaw_pct, output int n_bytes);
        logic [7:0] seq[$];
        int         len;
        int         flaw;
        int         kept;
        for (int i = 0; i < n_chars; i++) begin
            len  = $urandom_range(4, 1);
            flaw = ($urandom_range(99) < flaw_pct) ? $urandom_range(4, 1) : 0;
            if (flaw == 2 || flaw == 3) len = $urandom_range(4, 2);
            kept = $urandom_range(len - 2, 0);
            case (flaw)
                1: seq.push_back($urandom_range(1) ? 8'($urandom_range(8'hBF, 8'h80))
                                                   : 8'($urandom_range(8'hFF, 8'hF5)));
                2, 3: begin
                    // A cut character; flaw 3 then adds a byte that breaks it.
                    seq.push_back(lead_byte(len));
                    repeat (kept) seq.push_back(cont_byte());
                    if (flaw == 3)
                        seq.push_back($urandom_range(1) ? 8'($urandom_range(8'h7F, 8'h00))
                                                        : 8'($urandom_range(8'hFF, 8'hC0)));
                end
                4: seq.push_back(8'($urandom_range(8'hFF, 8'h00)));
                default: begin
                    seq.push_back(lead_byte(len));
                    repeat (len - 1) seq.push_back(cont_byte());
                end
            endcase
        end
        foreach (seq[k]) bytes_to_send.push_back({seq[k], k == seq.size() - 1});
        n_bytes = seq.size();
    endtask

    task automatic random_traffic(input int n_items);
        int sent;
        int n;
        sent = 0;
        while (sent < n_items) begin
            queue_string($urandom_range(10, 1), 20, n);
            sent += n;
        end
    endtask

    task automatic wait_for_drain();
        while (bytes_to_send.size() != 0 || bytes_taken != bytes_offered || chars_due.size() != 0)
            @(negedge i_clk);
    endtask

    initial begin
        // The error string ends on a cut character at the end of the string.
        for (int k = 0; k < $size(GOOD_RUN); k++)
            bytes_to_send.push_back({GOOD_RUN[k], 1'b0});
        bytes_to_send.push_back({8'hBF, 1'b1});
        for (int k = 0; k < $size(BAD_RUN); k++)
            bytes_to_send.push_back({BAD_RUN[k], 1'b0});
        bytes_to_send.push_back({8'hC3, 1'b1});

        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        random_traffic(220);
        wait_for_drain();

        send_gap_pct   = 74;
        take_stall_pct = 14;
        random_traffic(220);
        wait_for_drain();

        // Full rate from here on.
        send_gap_pct   = 0;
        take_stall_pct = 0;
        random_traffic(210);
        wait_for_drain();
        repeat (SETTLE) @(negedge i_clk);

        if (mismatch_count == 0 && chars_due.size() == 0) begin
            $display("[utf8_stream_decoder_core] OK");
        end else begin
            $display("[utf8_stream_decoder_core] ERROR");
        end
        $finish;
    end

endmodule
